// ===== rtl/lzop_pkg.sv =====
// Shared types, constants, datapath op codes and cost helpers for the LZ optimal-parse packer.
// No dependencies; the top level, datapath and controller import this package.
`timescale 1ns / 1ps
`default_nettype none

package lzop_pkg;

    localparam int BLOCK_BYTES_DEF = 32;
    localparam int OUT_MAX         = 64;
    localparam int POS_W           = 6;
    localparam int COST_W          = 18;
    localparam int CNT_W           = 7;

    localparam logic [COST_W-1:0] NO_PATH_COST  = COST_W'(16 * 1024 * 8);
    localparam logic [COST_W-1:0] END_CODE_BITS = COST_W'(1 + 8);
    localparam logic [7:0]        TOP_FLAG      = 8'd128;
    localparam logic [7:0]        EOF_BYTE      = 8'd255;
    localparam logic [7:0]        OFF_BASE      = 8'd254;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [4:0]       op_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_block;
    } in_word_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } out_word_t;

    typedef struct packed {
        logic [COST_W-1:0] bits;
        pos_t              len;
        pos_t              off;
        logic              next;
    } cell_t;

    typedef struct packed {
        logic load_last;
        logic o_last;
        logic p_zero;
        logic src_zero;
        logic in_range;
        logic bytes_eq;
        logic k_last;
        logic pk_done;
        logic cell_bad;
        logic pk_copy;
        logic off_same;
        logic bidx_zero;
        logic k_done;
        logic em_last;
    } status_t;

    localparam op_t OP_NONE     = 5'd0;
    localparam op_t OP_LOAD     = 5'd1;
    localparam op_t OP_EOF_INIT = 5'd2;
    localparam op_t OP_O_START  = 5'd3;
    localparam op_t OP_M_RD     = 5'd4;
    localparam op_t OP_NEXT_SRC = 5'd5;
    localparam op_t OP_M_HIT    = 5'd6;
    localparam op_t OP_C_USE    = 5'd7;
    localparam op_t OP_LIT_INIT = 5'd8;
    localparam op_t OP_L_RD     = 5'd9;
    localparam op_t OP_L_USE    = 5'd10;
    localparam op_t OP_WR       = 5'd11;
    localparam op_t OP_PK_INIT  = 5'd12;
    localparam op_t OP_PK_RD    = 5'd13;
    localparam op_t OP_PK_DEC   = 5'd14;
    localparam op_t OP_BIT0     = 5'd15;
    localparam op_t OP_BIT1     = 5'd16;
    localparam op_t OP_BYTE_OFF = 5'd17;
    localparam op_t OP_LEN_INIT = 5'd18;
    localparam op_t OP_BIT_LEN  = 5'd19;
    localparam op_t OP_LEN_END  = 5'd20;
    localparam op_t OP_B_RD     = 5'd21;
    localparam op_t OP_B_WR     = 5'd22;
    localparam op_t OP_ADV      = 5'd23;
    localparam op_t OP_BYTE_FF  = 5'd24;
    localparam op_t OP_EM_INIT  = 5'd25;
    localparam op_t OP_EM_OUT   = 5'd26;

    function automatic logic [2:0] msb_index(input pos_t v);
        logic [2:0] m;
        m = 3'd0;
        for (int i = 0; i < POS_W; i++) begin
            if (v[i]) begin
                m = 3'(i);
            end
        end
        return m;
    endfunction

    function automatic logic [3:0] gamma_bits(input pos_t len);
        return {msb_index(len), 1'b1};
    endfunction

    // keep the cheaper candidate; equal cost goes to the shorter length
    function automatic cell_t consider(input cell_t cur, input logic [COST_W-1:0] bits,
                                       input pos_t len, input pos_t off, input logic next);
        cell_t r;
        r = cur;
        if (bits < cur.bits || (bits == cur.bits && len < cur.len)) begin
            r.bits = bits;
            r.len  = len;
            r.off  = off;
            r.next = next;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lz_optimal_parse_packer.sv =====
// Top level of the LZ optimal-parse packer: controller plus datapath.
// Depends on lzop_pkg, lzop_ctrl, lzop_datapath (and lzop_ram through it).
//
// Usage:
//   Input words (item: in_byte, end_of_block) are taken on a rising edge with
//   start high and busy low. Bytes load one per cycle. The word with
//   end_of_block set, or the one that fills BLOCK_BYTES positions, closes the
//   block and raises busy.
//   Compression then runs a backward cost sweep over every position and offset
//   class (BLOCK_BYTES classes). Per position and class it reads and compares
//   bytes against every earlier position, updates the copy cost per matched
//   length and reads and costs each literal run length; the sweep is bound by the
//   single read port of the two cost tables. Packing walks the chosen path,
//   writing flag and length bits and copying each raw byte with a read and a
//   write; the packed words then leave one at a time, each read from the
//   output buffer before it is shown:
//   strobe marks each word for one cycle on result, last_byte flags the final
//   one, and busy drops after it. The receiver cannot stall the result channel.
//   Reset (rst_n low, asynchronous) returns to idle with an empty block.
`timescale 1ns / 1ps
`default_nettype none

module lz_optimal_parse_packer
    import lzop_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire in_word_t item,
    output out_word_t     result,
    output logic          strobe
);

    op_t     op;
    status_t status;

    lzop_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .status(status),
        .op(op),
        .busy(busy)
    );

    lzop_datapath #(.BLOCK_BYTES(BLOCK_BYTES)) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .op(op),
        .item(item),
        .status(status),
        .result(result),
        .strobe(strobe)
    );

endmodule

`default_nettype wire

// ===== rtl/lzop_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lzop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/lzop_datapath.sv =====
// Datapath: block byte store, cost tables, DP accumulators, bit packer and output buffer.
// Depends on lzop_pkg and lzop_ram; driven by op codes from lzop_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module lzop_datapath
    import lzop_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire op_t      op,
    input  wire in_word_t item,
    output status_t       status,
    output out_word_t     result,
    output logic          strobe
);

    localparam int NOFF   = BLOCK_BYTES;
    localparam int TDEPTH = (BLOCK_BYTES + 1) * NOFF;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int BAW    = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int OAW    = $clog2(OUT_MAX);
    localparam int CW     = $bits(cell_t);

    pos_t size_reg, size_next, pos_reg, pos_next, p_reg, p_next, o_reg, o_next;
    pos_t src_reg, src_next, len_reg, len_next;
    cell_t acc_c_reg, acc_c_next, acc_l_reg, acc_l_next, pk_reg, pk_next;
    logic pk_copy_reg, pk_copy_next;
    logic [2:0] bidx_reg, bidx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, fpos_reg, fpos_next, eidx_reg, eidx_next;
    logic [7:0] fval_reg, fval_next, fmask_reg, fmask_next;

    logic [POS_W:0] plen, srclen;
    pos_t off;
    logic [7:0] byte_a_q, byte_b_q, out_q;
    cell_t lit_q, copy_q, sel, cell_wdata_l, cell_wdata_c;
    logic [CW-1:0] lit_qv, copy_qv;
    logic tbl_we;
    logic [TAW-1:0] tbl_waddr, tbl_raddr;
    logic byte_we;
    logic out_we;
    logic [OAW-1:0] out_waddr;
    logic [7:0] out_wdata;
    logic put_bit_en, put_bit_val, put_byte_en;
    logic [7:0] put_byte_val, fval_new;
    logic [COST_W-1:0] head;
    cell_t acc_tmp;
    pos_t lbits;

    function automatic logic [TAW-1:0] taddr(input pos_t row, input pos_t col);
        return TAW'(32'(row) * NOFF + 32'(col));
    endfunction

    assign plen   = {1'b0, p_reg} + {1'b0, len_reg};
    assign srclen = {1'b0, src_reg} + {1'b0, len_reg};
    assign off    = p_reg - src_reg - pos_t'(1);
    assign lit_q  = cell_t'(lit_qv);
    assign copy_q = cell_t'(copy_qv);
    assign sel    = pk_copy_reg ? copy_q : lit_q;
    assign lbits  = pk_reg.len >> (bidx_reg - 3'd1);

    assign byte_we = (op == OP_LOAD);

    lzop_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_byte_a (
        .clk(clk), .we(byte_we), .waddr(BAW'(pos_reg)), .wdata(item.in_byte),
        .raddr(BAW'(plen)), .rdata(byte_a_q)
    );

    lzop_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_byte_b (
        .clk(clk), .we(byte_we), .waddr(BAW'(pos_reg)), .wdata(item.in_byte),
        .raddr(BAW'(srclen)), .rdata(byte_b_q)
    );

    always_comb
    begin
        tbl_we       = (op == OP_EOF_INIT) || (op == OP_WR);
        tbl_waddr    = (op == OP_EOF_INIT) ? taddr(size_reg, o_reg) : taddr(p_reg, o_reg);
        cell_wdata_l = acc_l_reg;
        cell_wdata_c = acc_c_reg;
        if (op == OP_EOF_INIT)
        begin
            cell_wdata_l = '{bits: END_CODE_BITS, len: '0, off: '0, next: 1'b0};
            cell_wdata_c = cell_wdata_l;
        end
        case (op)
            OP_M_HIT: tbl_raddr = taddr(pos_t'(plen + 1'b1), off);
            OP_L_RD:  tbl_raddr = taddr(pos_t'(plen), o_reg);
            default:  tbl_raddr = taddr(p_reg, o_reg);
        endcase
    end

    lzop_ram #(.WIDTH(CW), .DEPTH(TDEPTH)) u_lit_tbl (
        .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(cell_wdata_l),
        .raddr(tbl_raddr), .rdata(lit_qv)
    );

    lzop_ram #(.WIDTH(CW), .DEPTH(TDEPTH)) u_copy_tbl (
        .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(cell_wdata_c),
        .raddr(tbl_raddr), .rdata(copy_qv)
    );

    lzop_ram #(.WIDTH(8), .DEPTH(OUT_MAX)) u_out_buf (
        .clk(clk), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
        .raddr(OAW'(eidx_reg)), .rdata(out_q)
    );

    always_comb
    begin
        put_bit_en   = 1'b0;
        put_bit_val  = 1'b0;
        put_byte_en  = 1'b0;
        put_byte_val = 8'd0;
        case (op)
            OP_BIT0, OP_LEN_END: put_bit_en = 1'b1;
            OP_BIT1:
            begin
                put_bit_en  = 1'b1;
                put_bit_val = 1'b1;
            end
            OP_BIT_LEN:
            begin
                put_bit_en  = 1'b1;
                put_bit_val = lbits[0];
            end
            OP_BYTE_OFF:
            begin
                put_byte_en  = 1'b1;
                put_byte_val = OFF_BASE - 8'(pk_reg.off);
            end
            OP_B_WR:
            begin
                put_byte_en  = 1'b1;
                put_byte_val = byte_a_q;
            end
            OP_BYTE_FF:
            begin
                put_byte_en  = 1'b1;
                put_byte_val = EOF_BYTE;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        size_next    = size_reg;
        pos_next     = pos_reg;
        p_next       = p_reg;
        o_next       = o_reg;
        src_next     = src_reg;
        len_next     = len_reg;
        acc_c_next   = acc_c_reg;
        acc_l_next   = acc_l_reg;
        pk_next      = pk_reg;
        pk_copy_next = pk_copy_reg;
        bidx_next    = bidx_reg;
        cnt_next     = cnt_reg;
        fpos_next    = fpos_reg;
        fval_next    = fval_reg;
        fmask_next   = fmask_reg;
        eidx_next    = eidx_reg;
        out_we       = 1'b0;
        out_waddr    = OAW'(cnt_reg);
        out_wdata    = put_byte_val;
        head         = '0;
        acc_tmp      = acc_c_reg;
        fval_new     = 8'd0;

        if (put_byte_en)
        begin
            if (cnt_reg < CNT_W'(OUT_MAX))
            begin
                out_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (put_bit_en)
        begin
            if (fmask_reg == 8'd0)
            begin
                fval_new   = put_bit_val ? TOP_FLAG : 8'd0;
                fpos_next  = cnt_reg;
                fmask_next = TOP_FLAG >> 1;
                if (cnt_reg < CNT_W'(OUT_MAX))
                begin
                    out_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            else
            begin
                fval_new   = fval_reg | (put_bit_val ? fmask_reg : 8'd0);
                fmask_next = fmask_reg >> 1;
                out_waddr  = OAW'(fpos_reg);
                out_we     = (fpos_reg < CNT_W'(OUT_MAX));
            end
            fval_next = fval_new;
            out_wdata = fval_new;
        end

        case (op)
            OP_LOAD:
            begin
                o_next = '0;
                if (status.load_last)
                begin
                    size_next = pos_reg + pos_t'(1);
                    pos_next  = '0;
                end
                else
                begin
                    pos_next = pos_reg + pos_t'(1);
                end
            end
            OP_EOF_INIT:
            begin
                o_next = status.o_last ? pos_t'(0) : o_reg + pos_t'(1);
                if (status.o_last)
                begin
                    p_next = size_reg - pos_t'(1);
                end
            end
            OP_O_START:
            begin
                acc_c_next = '{bits: NO_PATH_COST, len: '0, off: '0, next: 1'b0};
                acc_l_next = acc_c_next;
                src_next   = p_reg - pos_t'(1);
                len_next   = '0;
            end
            OP_NEXT_SRC:
            begin
                src_next = src_reg - pos_t'(1);
                len_next = '0;
            end
            OP_M_HIT: len_next = len_reg + pos_t'(1);
            OP_C_USE:
            begin
                head = COST_W'(1) + ((off != o_reg) ? COST_W'(8) : COST_W'(0))
                     + COST_W'(gamma_bits(len_reg));
                acc_tmp = consider(acc_c_reg, head + lit_q.bits, len_reg, off, 1'b0);
                if (off != copy_q.off)
                begin
                    acc_tmp = consider(acc_tmp, head + copy_q.bits, len_reg, off, 1'b1);
                end
                acc_c_next = acc_tmp;
            end
            OP_LIT_INIT: len_next = pos_t'(1);
            OP_L_USE:
            begin
                head = COST_W'(1) + COST_W'({len_reg, 3'b000})
                     + COST_W'(gamma_bits(len_reg));
                acc_l_next = consider(acc_l_reg, head + copy_q.bits, len_reg, o_reg, 1'b1);
                len_next   = len_reg + pos_t'(1);
            end
            OP_WR:
            begin
                o_next = status.o_last ? pos_t'(0) : o_reg + pos_t'(1);
                if (status.o_last)
                begin
                    p_next = p_reg - pos_t'(1);
                end
            end
            OP_PK_INIT:
            begin
                p_next       = '0;
                o_next       = '0;
                pk_copy_next = 1'b0;
                cnt_next     = '0;
                fmask_next   = 8'd0;
            end
            OP_PK_DEC:   pk_next = sel;
            OP_LEN_INIT: bidx_next = msb_index(pk_reg.len);
            OP_BIT_LEN:  bidx_next = bidx_reg - 3'd1;
            OP_LEN_END:  len_next = '0;
            OP_B_WR:     len_next = len_reg + pos_t'(1);
            OP_ADV:
            begin
                p_next       = p_reg + pk_reg.len;
                o_next       = pk_reg.off;
                pk_copy_next = pk_reg.next;
            end
            OP_EM_INIT:  eidx_next = '0;
            OP_EM_OUT:   eidx_next = eidx_reg + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= '0;
            pos_reg     <= '0;
            p_reg       <= '0;
            o_reg       <= '0;
            src_reg     <= '0;
            len_reg     <= '0;
            pk_copy_reg <= 1'b0;
            bidx_reg    <= '0;
            cnt_reg     <= '0;
            fpos_reg    <= '0;
            fmask_reg   <= '0;
            eidx_reg    <= '0;
        end
        else
        begin
            size_reg    <= size_next;
            pos_reg     <= pos_next;
            p_reg       <= p_next;
            o_reg       <= o_next;
            src_reg     <= src_next;
            len_reg     <= len_next;
            pk_copy_reg <= pk_copy_next;
            bidx_reg    <= bidx_next;
            cnt_reg     <= cnt_next;
            fpos_reg    <= fpos_next;
            fmask_reg   <= fmask_next;
            eidx_reg    <= eidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_c_reg <= acc_c_next;
        acc_l_reg <= acc_l_next;
        pk_reg    <= pk_next;
        fval_reg  <= fval_next;
    end

    always_comb
    begin
        status.load_last = item.end_of_block || (pos_reg == pos_t'(BLOCK_BYTES - 1));
        status.o_last    = (o_reg == pos_t'(NOFF - 1));
        status.p_zero    = (p_reg == '0);
        status.src_zero  = (src_reg == '0);
        status.in_range  = (plen < {1'b0, size_reg});
        status.bytes_eq  = (byte_a_q == byte_b_q);
        status.k_last    = (plen == {1'b0, size_reg});
        status.pk_done   = (p_reg == size_reg);
        status.cell_bad  = (sel.len == '0)
                        || (({1'b0, p_reg} + {1'b0, sel.len}) > {1'b0, size_reg});
        status.pk_copy   = pk_copy_reg;
        status.off_same  = (o_reg == pk_reg.off);
        status.bidx_zero = (bidx_reg == 3'd0);
        status.k_done    = ((len_reg + pos_t'(1)) == pk_reg.len);
        status.em_last   = ((eidx_reg + 1'b1) == cnt_reg);
    end

    assign result.packed_byte = out_q;
    assign result.last_byte   = status.em_last;
    assign strobe             = (op == OP_EM_OUT);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(OUT_MAX))
        else $error("output count past buffer");

    a_flag_mask: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fmask_reg))
        else $error("flag mask not one-hot");

    a_wr_row: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_WR) |-> (p_reg < size_reg))
        else $error("cost write outside block");

endmodule

`default_nettype wire

// ===== rtl/lzop_ctrl.sv =====
// Controller: sequences load, backward DP sweep, stream packing and word emission.
// Depends on lzop_pkg; issues op codes to lzop_datapath and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module lzop_ctrl
    import lzop_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output op_t          op,
    output logic         busy
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_EOF_INIT = 5'd1;
    localparam logic [4:0] ST_O_START  = 5'd2;
    localparam logic [4:0] ST_M_RD     = 5'd3;
    localparam logic [4:0] ST_M_CMP    = 5'd4;
    localparam logic [4:0] ST_C_USE    = 5'd5;
    localparam logic [4:0] ST_LIT_INIT = 5'd6;
    localparam logic [4:0] ST_L_RD     = 5'd7;
    localparam logic [4:0] ST_L_USE    = 5'd8;
    localparam logic [4:0] ST_WR       = 5'd9;
    localparam logic [4:0] ST_PK_INIT  = 5'd10;
    localparam logic [4:0] ST_PK_RD    = 5'd11;
    localparam logic [4:0] ST_PK_DEC   = 5'd12;
    localparam logic [4:0] ST_PK_F1    = 5'd13;
    localparam logic [4:0] ST_PK_OFFB  = 5'd14;
    localparam logic [4:0] ST_LEN_INIT = 5'd15;
    localparam logic [4:0] ST_LEN_A    = 5'd16;
    localparam logic [4:0] ST_LEN_B    = 5'd17;
    localparam logic [4:0] ST_B_RD     = 5'd18;
    localparam logic [4:0] ST_B_WR     = 5'd19;
    localparam logic [4:0] ST_PK_ADV   = 5'd20;
    localparam logic [4:0] ST_EOF1     = 5'd21;
    localparam logic [4:0] ST_EOF2     = 5'd22;
    localparam logic [4:0] ST_EM_INIT  = 5'd23;
    localparam logic [4:0] ST_EM_RD    = 5'd24;
    localparam logic [4:0] ST_EM_OUT   = 5'd25;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op = OP_LOAD;
                    if (status.load_last)
                    begin
                        state_next = ST_EOF_INIT;
                    end
                end
            end
            ST_EOF_INIT:
            begin
                op = OP_EOF_INIT;
                if (status.o_last)
                begin
                    state_next = ST_O_START;
                end
            end
            ST_O_START:
            begin
                op         = OP_O_START;
                state_next = status.p_zero ? ST_LIT_INIT : ST_M_RD;
            end
            ST_M_RD:
            begin
                if (status.in_range)
                begin
                    op         = OP_M_RD;
                    state_next = ST_M_CMP;
                end
                else
                begin
                    op         = OP_NEXT_SRC;
                    state_next = status.src_zero ? ST_LIT_INIT : ST_M_RD;
                end
            end
            ST_M_CMP:
            begin
                if (status.bytes_eq)
                begin
                    op         = OP_M_HIT;
                    state_next = ST_C_USE;
                end
                else
                begin
                    op         = OP_NEXT_SRC;
                    state_next = status.src_zero ? ST_LIT_INIT : ST_M_RD;
                end
            end
            ST_C_USE:
            begin
                op         = OP_C_USE;
                state_next = ST_M_RD;
            end
            ST_LIT_INIT:
            begin
                op         = OP_LIT_INIT;
                state_next = ST_L_RD;
            end
            ST_L_RD:
            begin
                op         = OP_L_RD;
                state_next = ST_L_USE;
            end
            ST_L_USE:
            begin
                op         = OP_L_USE;
                state_next = status.k_last ? ST_WR : ST_L_RD;
            end
            ST_WR:
            begin
                op         = OP_WR;
                state_next = (status.o_last && status.p_zero) ? ST_PK_INIT : ST_O_START;
            end
            ST_PK_INIT:
            begin
                op         = OP_PK_INIT;
                state_next = ST_PK_RD;
            end
            ST_PK_RD:
            begin
                if (status.pk_done)
                begin
                    state_next = ST_EOF1;
                end
                else
                begin
                    op         = OP_PK_RD;
                    state_next = ST_PK_DEC;
                end
            end
            ST_PK_DEC:
            begin
                op         = OP_PK_DEC;
                state_next = status.cell_bad ? ST_EOF1 : ST_PK_F1;
            end
            ST_PK_F1:
            begin
                state_next = ST_LEN_INIT;
                if (!status.pk_copy)
                begin
                    op = status.p_zero ? OP_NONE : OP_BIT0;
                end
                else if (status.off_same)
                begin
                    op = OP_BIT0;
                end
                else
                begin
                    op         = OP_BIT1;
                    state_next = ST_PK_OFFB;
                end
            end
            ST_PK_OFFB:
            begin
                op         = OP_BYTE_OFF;
                state_next = ST_LEN_INIT;
            end
            ST_LEN_INIT:
            begin
                op         = OP_LEN_INIT;
                state_next = ST_LEN_A;
            end
            ST_LEN_A:
            begin
                if (status.bidx_zero)
                begin
                    op         = OP_LEN_END;
                    state_next = status.pk_copy ? ST_PK_ADV : ST_B_RD;
                end
                else
                begin
                    op         = OP_BIT1;
                    state_next = ST_LEN_B;
                end
            end
            ST_LEN_B:
            begin
                op         = OP_BIT_LEN;
                state_next = ST_LEN_A;
            end
            ST_B_RD:
            begin
                op         = OP_B_RD;
                state_next = ST_B_WR;
            end
            ST_B_WR:
            begin
                op         = OP_B_WR;
                state_next = status.k_done ? ST_PK_ADV : ST_B_RD;
            end
            ST_PK_ADV:
            begin
                op         = OP_ADV;
                state_next = ST_PK_RD;
            end
            ST_EOF1:
            begin
                op         = OP_BIT1;
                state_next = ST_EOF2;
            end
            ST_EOF2:
            begin
                op         = OP_BYTE_FF;
                state_next = ST_EM_INIT;
            end
            ST_EM_INIT:
            begin
                op         = OP_EM_INIT;
                state_next = ST_EM_RD;
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                op         = OP_EM_OUT;
                state_next = status.em_last ? ST_IDLE : ST_EM_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_LOAD) |-> !busy)
        else $error("load while busy");

    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && status.load_last) |=> busy)
        else $error("final byte did not start compression");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_OUT && status.em_last) |=> !busy)
        else $error("block did not finish after last word");

endmodule

`default_nettype wire
